[rtl/btx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btx_pkg: shared types, constants and arithmetic helpers
// Types, command codes, default sizes and the packed blend used by the
// bilinear texture sampler.
// ----------------------------------------------------------------------------
package btx_pkg;

	localparam int TEX_AW_DEF  = 16;    // texture memory address bits (65536 words)
	localparam int MAX_DIM_DEF = 4096;  // largest width or height in texels

	localparam int MAG_W      = 24;     // bits of a texel index magnitude
	localparam int MOD_STEP   = 4;      // remainder steps done per stage
	localparam int MOD_STAGES = (MAG_W + MOD_STEP - 1) / MOD_STEP;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_S_SCALE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_T_SCALE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_S   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_T   = 3'd5;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam logic [31:0] MASK_A = 32'h00ff00ff;
	localparam logic [31:0] MASK_B = 32'hff00ff00;

	typedef struct packed {
		logic [12:0] tex_width;
		logic [12:0] tex_height;
		logic [23:0] s_scale;
		logic [23:0] t_scale;
		logic        repeat_s;
		logic        repeat_t;
	} cfg_t;

	// One transaction as it leaves the front part.
	typedef struct packed {
		logic               cmd;
		logic signed [31:0] fix_s;
		logic signed [31:0] fix_t;
		logic [15:0]        texel_addr;
		logic [31:0]        texel_value;
	} item_t;

	// One transaction inside the back part.
	typedef struct packed {
		logic                   cmd;
		logic signed [MAG_W-1:0] idx_s;
		logic signed [MAG_W-1:0] idx_t;
		logic [7:0]             frac_s;
		logic [7:0]             frac_t;
		logic [15:0]            texel_addr;
		logic [31:0]            texel_value;
	} smp_t;

	// Scaled magnitude (product >> 16) saturated to signed 32 bits.
	function automatic logic signed [31:0] sat_fix(input logic neg, input logic [55:0] prod);
		logic [39:0] q;
		logic [31:0] m;
		begin
			q = prod[55:16];
			if (neg) begin
				m = (q > 40'h0080000000) ? 32'h80000000 : q[31:0];
				sat_fix = $signed(~m + 32'd1);
			end else begin
				m = (q > 40'h007fffffff) ? 32'h7fffffff : q[31:0];
				sat_fix = $signed(m);
			end
		end
	endfunction

	// Packed lerp of two channel pairs at once, 32-bit wrapping arithmetic.
	function automatic logic [31:0] blend(input logic [31:0] c1, input logic [31:0] c2,
			input logic [7:0] w);
		logic [31:0] a1, b1, a2, b2, wx, lo, hi;
		begin
			a1 = c1 & MASK_A;
			b1 = c1 & MASK_B;
			a2 = c2 & MASK_A;
			b2 = c2 & MASK_B;
			wx = {24'd0, w};
			lo = (((a1 << 8) + (a2 - a1) * wx) >> 8) & MASK_A;
			hi = (b1 + ((b2 >> 8) - (b1 >> 8)) * wx) & MASK_B;
			blend = lo | hi;
		end
	endfunction

endpackage

[rtl/btx_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btx_front: input stage and coordinate scaling
// Accepts transactions, scales both coordinates into texel units with eight
// fractional bits and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module btx_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 cmd,
	input  logic signed [31:0]   coord_s,
	input  logic signed [31:0]   coord_t,
	input  logic [15:0]          texel_addr,
	input  logic [31:0]          texel_value,
	input  btx_pkg::cfg_t        cfg,
	output logic                 push,
	output btx_pkg::item_t       push_item,
	input  logic                 full
);

	logic        fe;
	logic        v_s1, v_s2;
	logic        cmd_s1, cmd_s2;
	logic        neg_s_s1, neg_t_s1, neg_s_s2, neg_t_s2;
	logic [31:0] mag_s_s1, mag_t_s1;
	logic [55:0] prod_s_s2, prod_t_s2;
	logic [15:0] addr_s1, addr_s2;
	logic [31:0] val_s1, val_s2;

	// The whole front advances unless its last item cannot enter the queue.
	assign fe       = !(v_s2 && full);
	assign in_stall = !fe;
	assign push     = v_s2 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (fe) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			cmd_s1   <= cmd;
			neg_s_s1 <= coord_s[31];
			neg_t_s1 <= coord_t[31];
			mag_s_s1 <= coord_s[31] ? (~coord_s + 32'd1) : coord_s;
			mag_t_s1 <= coord_t[31] ? (~coord_t + 32'd1) : coord_t;
			addr_s1  <= texel_addr;
			val_s1   <= texel_value;

			cmd_s2    <= cmd_s1;
			neg_s_s2  <= neg_s_s1;
			neg_t_s2  <= neg_t_s1;
			prod_s_s2 <= 56'(mag_s_s1) * 56'(cfg.s_scale);
			prod_t_s2 <= 56'(mag_t_s1) * 56'(cfg.t_scale);
			addr_s2   <= addr_s1;
			val_s2    <= val_s1;
		end
	end

	always_comb begin
		push_item.cmd         = cmd_s2;
		push_item.fix_s       = btx_pkg::sat_fix(neg_s_s2, prod_s_s2);
		push_item.fix_t       = btx_pkg::sat_fix(neg_t_s2, prod_t_s2);
		push_item.texel_addr  = addr_s2;
		push_item.texel_value = val_s2;
	end

endmodule

[rtl/btx_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btx_queue: four-entry queue between front and back
// Decouples the stall of the back part from the input side.
// ----------------------------------------------------------------------------
module btx_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  btx_pkg::item_t  push_item,
	output logic            full,
	input  logic            pop,
	output btx_pkg::item_t  pop_item,
	output logic            not_empty
);

	localparam int DEPTH = 4;

	btx_pkg::item_t store_q [DEPTH];
	logic [1:0]     wr_ptr_q, rd_ptr_q;
	logic [2:0]     count_q;

	assign full      = (count_q == 3'(DEPTH));
	assign not_empty = (count_q != 3'd0);
	assign pop_item  = store_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 2'd1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 2'd1;
			if (push && !pop)
				count_q <= count_q + 3'd1;
			else if (pop && !push)
				count_q <= count_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			store_q[wr_ptr_q] <= push_item;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'(DEPTH)) else $error("queue count out of range");
	a_fill_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop && count_q == 3'(DEPTH - 1)) |=> full)
		else $error("queue did not report full");

endmodule

[rtl/btx_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btx_back: index reduction, texel fetch and bilinear blend
// Pipelined remainder, neighbour selection, address generation, four
// replicated texture banks and the two-level packed lerp.
// ----------------------------------------------------------------------------
module btx_back #(
	parameter int TEX_AW  = btx_pkg::TEX_AW_DEF,
	parameter int MAX_DIM = btx_pkg::MAX_DIM_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  btx_pkg::cfg_t   cfg,
	input  btx_pkg::item_t  pop_item,
	input  logic            not_empty,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [31:0]     color
);

	localparam int TEX_WORDS = 1 << TEX_AW;
	localparam int DW  = $clog2(MAX_DIM + 1);
	localparam int IW  = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
	localparam int PW  = IW + DW;
	localparam int MW  = btx_pkg::MAG_W;
	localparam int NST = btx_pkg::MOD_STAGES;

	logic          be;
	logic [DW-1:0] dim_w, dim_h;

	// Remainder state of the restoring reduction.
	typedef struct packed {
		logic [DW-1:0] rem;
		logic [MW-1:0] mag;
	} red_t;

	function automatic red_t reduce(input red_t x, input logic [DW-1:0] n);
		logic [DW:0] r;
		red_t        y;
		begin
			y = x;
			for (int k = 0; k < btx_pkg::MOD_STEP; k++) begin
				r     = {y.rem, y.mag[MW-1]};
				y.mag = y.mag << 1;
				if (r >= {1'b0, n})
					r = r - {1'b0, n};
				y.rem = r[DW-1:0];
			end
			reduce = y;
		end
	endfunction

	function automatic logic [DW-1:0] eff_dim(input logic [12:0] d);
		logic [31:0] e;
		begin
			if (d == 13'd0)
				e = 32'd1;
			else if ({19'd0, d} > 32'(MAX_DIM))
				e = 32'(MAX_DIM);
			else
				e = {19'd0, d};
			eff_dim = e[DW-1:0];
		end
	endfunction

	assign dim_w = eff_dim(cfg.tex_width);
	assign dim_h = eff_dim(cfg.tex_height);

	// The whole back part holds while a finished colour waits to be taken.
	assign be  = !(out_valid && out_stall);
	assign pop = be && not_empty;

	// Reduction pipeline, stage 0 is the item taken from the queue.
	logic           v_md_q   [NST+1];
	btx_pkg::smp_t  it_md_q  [NST+1];
	red_t           rs_md_q  [NST+1];
	red_t           rt_md_q  [NST+1];

	btx_pkg::smp_t  pop_smp;
	logic [MW-1:0]  idx_s_pop, idx_t_pop;

	always_comb begin
		pop_smp.cmd         = pop_item.cmd;
		pop_smp.idx_s       = pop_item.fix_s[31:8];
		pop_smp.idx_t       = pop_item.fix_t[31:8];
		pop_smp.frac_s      = pop_item.fix_s[7:0];
		pop_smp.frac_t      = pop_item.fix_t[7:0];
		pop_smp.texel_addr  = pop_item.texel_addr;
		pop_smp.texel_value = pop_item.texel_value;
		idx_s_pop = pop_smp.idx_s;
		idx_t_pop = pop_smp.idx_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NST; k++)
				v_md_q[k] <= 1'b0;
		end else if (be) begin
			v_md_q[0] <= not_empty;
			for (int k = 1; k <= NST; k++)
				v_md_q[k] <= v_md_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			it_md_q[0]     <= pop_smp;
			rs_md_q[0].rem <= '0;
			rs_md_q[0].mag <= idx_s_pop[MW-1] ? (~idx_s_pop + 1'b1) : idx_s_pop;
			rt_md_q[0].rem <= '0;
			rt_md_q[0].mag <= idx_t_pop[MW-1] ? (~idx_t_pop + 1'b1) : idx_t_pop;
			for (int k = 1; k <= NST; k++) begin
				it_md_q[k] <= it_md_q[k-1];
				rs_md_q[k] <= reduce(rs_md_q[k-1], dim_w);
				rt_md_q[k] <= reduce(rt_md_q[k-1], dim_h);
			end
		end
	end

	// Neighbour selection: wrap (Euclidean) or clamp per axis.
	function automatic logic [2*IW-1:0] pick(input logic signed [MW-1:0] idx,
			input logic [DW-1:0] rem, input logic [DW-1:0] n, input logic wrap);
		logic [DW-1:0]      r, r1;
		logic signed [31:0] ix, hi;
		logic [31:0]        c0, c1;
		begin
			if (wrap) begin
				r  = (idx < 0 && rem != '0) ? (n - rem) : rem;
				r1 = (r + 1'b1 == n) ? '0 : r + 1'b1;
				pick = {IW'(r1), IW'(r)};
			end else begin
				ix = 32'(idx);
				hi = $signed(32'(n)) - 32'sd1;
				if (ix < 0)
					c0 = 32'd0;
				else if (ix > hi)
					c0 = 32'(hi);
				else
					c0 = 32'(ix);
				c1 = ($signed(c0) + 32'sd1 > hi) ? 32'(hi) : c0 + 32'd1;
				pick = {c1[IW-1:0], c0[IW-1:0]};
			end
		end
	endfunction

	logic           v_sel_s1, v_row_s2, v_adr_s3, v_mem_s4, v_bl_s5;
	btx_pkg::smp_t  it_sel_s1, it_row_s2, it_adr_s3, it_mem_s4;
	logic [IW-1:0]  s0_s1, s1_s1, t0_s1, t1_s1, s0_s2, s1_s2;
	logic [PW-1:0]  row0_s2, row1_s2;
	logic [TEX_AW-1:0] a_s3 [4];
	logic [31:0]    tx_s4 [4];
	logic [31:0]    top_s5, bot_s5;
	logic [7:0]     ft_s5;
	logic           load_ok;
	logic [TEX_AW+15:0] waddr_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sel_s1 <= 1'b0;
			v_row_s2 <= 1'b0;
			v_adr_s3 <= 1'b0;
			v_mem_s4 <= 1'b0;
			v_bl_s5  <= 1'b0;
			out_valid <= 1'b0;
		end else if (be) begin
			v_sel_s1 <= v_md_q[NST];
			v_row_s2 <= v_sel_s1;
			v_adr_s3 <= v_row_s2;
			v_mem_s4 <= v_adr_s3;
			v_bl_s5  <= v_mem_s4 && it_mem_s4.cmd == btx_pkg::CMD_SAMPLE;
			out_valid <= v_bl_s5;
		end
	end

	function automatic logic [TEX_AW-1:0] addr_of(input logic [PW-1:0] row,
			input logic [IW-1:0] col);
		logic [PW+TEX_AW:0] s;
		begin
			s = (PW + TEX_AW + 1)'(row) + (PW + TEX_AW + 1)'(col);
			addr_of = s[TEX_AW-1:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		if (be) begin
			it_sel_s1        <= it_md_q[NST];
			{s1_s1, s0_s1}   <= pick(it_md_q[NST].idx_s, rs_md_q[NST].rem, dim_w,
				cfg.repeat_s);
			{t1_s1, t0_s1}   <= pick(it_md_q[NST].idx_t, rt_md_q[NST].rem, dim_h,
				cfg.repeat_t);

			it_row_s2 <= it_sel_s1;
			row0_s2   <= PW'(t0_s1) * PW'(dim_w);
			row1_s2   <= PW'(t1_s1) * PW'(dim_w);
			s0_s2     <= s0_s1;
			s1_s2     <= s1_s1;

			it_adr_s3 <= it_row_s2;
			a_s3[0]   <= addr_of(row0_s2, s0_s2);
			a_s3[1]   <= addr_of(row0_s2, s1_s2);
			a_s3[2]   <= addr_of(row1_s2, s0_s2);
			a_s3[3]   <= addr_of(row1_s2, s1_s2);

			it_mem_s4 <= it_adr_s3;

			top_s5 <= btx_pkg::blend(tx_s4[0], tx_s4[1], it_mem_s4.frac_s);
			bot_s5 <= btx_pkg::blend(tx_s4[2], tx_s4[3], it_mem_s4.frac_s);
			ft_s5  <= it_mem_s4.frac_t;

			color <= btx_pkg::blend(top_s5, bot_s5, ft_s5);
		end
	end

	// Loads write every bank in the same stage in which samples read, so
	// program order between loads and samples is kept.
	assign waddr_ext = (TEX_AW + 16)'(it_adr_s3.texel_addr);
	assign load_ok   = be && v_adr_s3 && it_adr_s3.cmd == btx_pkg::CMD_LOAD &&
		(32'(it_adr_s3.texel_addr) < 32'(TEX_WORDS));

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [31:0] bank_mem [TEX_WORDS];
		always_ff @(posedge clk) begin
			if (load_ok)
				bank_mem[waddr_ext[TEX_AW-1:0]] <= it_adr_s3.texel_value;
			if (be)
				tx_s4[b] <= bank_mem[a_s3[b]];
		end
	end

endmodule

[rtl/bilinear_texture_sampler_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_core: bilinear RGBA8888 texture sampler
// Texture memory with load and sample transactions and a packed bilinear
// filter.
// ----------------------------------------------------------------------------
// The sampler takes one transaction per clock and gives one filtered colour
// per clock for every sample transaction without stalls; load transactions
// give no output. A sample travels through the front stages (capture, scaling
// multiply, queue write), a four-entry queue, and a back pipeline: a capture
// register, six stages of the remainder unit (four dividend bits each),
// neighbour selection, row multiply, address add, a registered read of four
// replicated texture banks, and two blend stages. The remainder unit and the
// four-bank read are what set the back pipeline's length. A load writes all
// four banks at the same point of the pipeline where samples read, so a sample
// sees every load accepted before it. Configuration registers are written
// through a plain write port and are expected to change only while the
// sampler holds no transaction. The texture memory has no reset; a texel
// must be loaded before any sample reads it.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_core #(
	parameter int TEX_AW  = btx_pkg::TEX_AW_DEF,
	parameter int MAX_DIM = btx_pkg::MAX_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [btx_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [btx_pkg::CFG_DATA_W-1:0]    cfg_data,
	// Input transactions.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              cmd,
	input  logic signed [31:0]                coord_s,
	input  logic signed [31:0]                coord_t,
	input  logic [15:0]                       texel_addr,
	input  logic [31:0]                       texel_value,
	// Result transactions.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [31:0]                       color
);

	btx_pkg::cfg_t  cfg_q;
	btx_pkg::item_t push_item, pop_item;
	logic           push, pop, full, not_empty;

	// Register file; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tex_width  <= 13'd1;
			cfg_q.tex_height <= 13'd1;
			cfg_q.s_scale    <= 24'd256;
			cfg_q.t_scale    <= 24'd256;
			cfg_q.repeat_s   <= 1'b0;
			cfg_q.repeat_t   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				btx_pkg::REG_TEX_WIDTH:  cfg_q.tex_width  <= cfg_data[12:0];
				btx_pkg::REG_TEX_HEIGHT: cfg_q.tex_height <= cfg_data[12:0];
				btx_pkg::REG_S_SCALE:    cfg_q.s_scale    <= cfg_data;
				btx_pkg::REG_T_SCALE:    cfg_q.t_scale    <= cfg_data;
				btx_pkg::REG_REPEAT_S:   cfg_q.repeat_s   <= cfg_data[0];
				btx_pkg::REG_REPEAT_T:   cfg_q.repeat_t   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	btx_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.coord_s     (coord_s),
		.coord_t     (coord_t),
		.texel_addr  (texel_addr),
		.texel_value (texel_value),
		.cfg         (cfg_q),
		.push        (push),
		.push_item   (push_item),
		.full        (full)
	);

	btx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.not_empty (not_empty)
	);

	btx_back #(
		.TEX_AW  (TEX_AW),
		.MAX_DIM (MAX_DIM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_item  (pop_item),
		.not_empty (not_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.color     (color)
	);

endmodule
